// ----- rtl/core/kld_pkg.sv -----
// shared types and constants for the kosinski decompressor
`timescale 1ns / 1ps

package kld_pkg;

    localparam int WINDOW_DEPTH = 8192;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int OUT_LANES    = 4;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    // status codes of a result item
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_FINISHED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_BAD_OFS  = 3'd4;

    typedef enum logic [3:0] {
        PH_FLAG1 = 4'd0,
        PH_FLAG2 = 4'd1,
        PH_IB1   = 4'd2,
        PH_IB2   = 4'd3,
        PH_LIT   = 4'd4,
        PH_MLO   = 4'd5,
        PH_MHI   = 4'd6,
        PH_MCNT  = 4'd7,
        PH_INL   = 4'd8,
        PH_DRAIN = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        LD_NONE = 2'd0,
        LD_LOW  = 2'd1,
        LD_HIGH = 2'd2
    } load_t;

    // what the decode cycle leads to
    typedef enum logic [2:0] {
        NX_IDLE  = 3'd0,
        NX_FLUSH = 3'd1,
        NX_ADV   = 3'd2,
        NX_LIT   = 3'd3,
        NX_AFTER = 3'd4,
        NX_COPY  = 3'd5
    } next_t;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_LOAD   = 4'd1,
        CMD_DECODE = 4'd2,
        CMD_CHECK  = 4'd3,
        CMD_PUSH   = 4'd4,
        CMD_READ   = 4'd5,
        CMD_WRITE  = 4'd6,
        CMD_AFTER  = 4'd7,
        CMD_ADV    = 4'd8,
        CMD_FLUSH  = 4'd9
    } cmd_t;

    typedef struct packed {
        next_t nx;
        logic  put_full;
        logic  copy_bad;
        logic  lanes_full;
        logic  cnt_last;
        logic  adv_more;
        logic  flush_need;
        logic  out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/kld_ctrl.sv -----
// controller state machine sequencing decode, copy and flush
`timescale 1ns / 1ps

module kld_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  kld_pkg::dp_status_t st,
    output kld_pkg::cmd_t       cmd
);
    import kld_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_WRITE  = 8'b0001_0000,
        S_AFTER  = 8'b0010_0000,
        S_ADV    = 8'b0100_0000,
        S_FLUSH  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd = CMD_DECODE;
                case (st.nx)
                    NX_IDLE:  state_next = S_IDLE;
                    NX_FLUSH: state_next = S_FLUSH;
                    NX_ADV:   state_next = S_ADV;
                    NX_LIT:   state_next = st.put_full ? S_FLUSH : S_AFTER;
                    NX_AFTER: state_next = S_AFTER;
                    NX_COPY:  state_next = S_CHECK;
                    default:  state_next = S_FLUSH;
                endcase
            end
            S_CHECK:
            begin
                cmd        = CMD_CHECK;
                state_next = st.copy_bad ? S_FLUSH : S_READ;
            end
            S_READ:
            begin
                if (st.lanes_full)
                begin
                    if (st.out_free)
                    begin
                        cmd = CMD_PUSH;
                    end
                end
                else
                begin
                    cmd        = CMD_READ;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd = CMD_WRITE;
                if (st.put_full)
                begin
                    state_next = S_FLUSH;
                end
                else if (st.cnt_last)
                begin
                    state_next = S_AFTER;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_AFTER:
            begin
                cmd        = CMD_AFTER;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (st.adv_more)
                begin
                    cmd = CMD_ADV;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!st.flush_need || st.out_free)
                begin
                    cmd        = CMD_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- rtl/core/kld_datapath.sv -----
// parse state, history window, lane packing and output register
`timescale 1ns / 1ps

module kld_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  kld_pkg::cmd_t       cmd,
    output kld_pkg::dp_status_t st,
    input  logic [7:0]          in_byte,
    input  logic                end_of_input,
    input  logic                cfg_write,
    input  logic [15:0]         output_limit,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         out_bytes,
    output logic [2:0]          byte_count,
    output logic [2:0]          status,
    output logic [15:0]         total_length,
    output logic                last
);
    import kld_pkg::*;

    logic [7:0]  mem [WINDOW_DEPTH];
    logic [7:0]  rd_data_reg;

    logic [7:0]  byte_reg;
    logic        eoi_reg;
    logic [15:0] limit_reg,  limit_next;
    logic [15:0] pos_reg,    pos_next;
    logic [15:0] desc_reg,   desc_next;
    logic [4:0]  left_reg,   left_next;
    phase_t      phase_reg,  phase_next;
    load_t       load_reg,   load_next;
    logic [7:0]  plo_reg,    plo_next;
    logic [7:0]  phi_reg,    phi_next;
    logic [1:0]  inl_reg,    inl_next;
    logic [13:0] dist_reg,   dist_next;
    logic [8:0]  cnt_reg,    cnt_next;
    logic [2:0]  stat_reg,   stat_next;
    logic [31:0] lanes_reg,  lanes_next;
    logic [2:0]  nlane_reg,  nlane_next;

    logic        ovalid_reg, ovalid_next;
    logic [31:0] obytes_reg, obytes_next;
    logic [2:0]  ocount_reg, ocount_next;
    logic [2:0]  ostat_reg,  ostat_next;
    logic [15:0] olen_reg,   olen_next;
    logic        olast_reg,  olast_next;

    logic              put_en;
    logic [7:0]        put_byte;
    logic [15:0]       pos_inc;
    logic              we;
    logic [WIN_AW-1:0] rd_addr;
    logic [2:0]        fin_stat;
    logic              out_free;
    logic              bit0;

    assign pos_inc  = pos_reg + 16'd1;
    assign rd_addr  = WIN_AW'(pos_reg - {2'b00, dist_reg});
    assign fin_stat = (stat_reg != ST_DATA) ? stat_reg : (eoi_reg ? ST_TRUNC : ST_DATA);
    assign out_free = !ovalid_reg || !out_stall;
    assign bit0     = desc_reg[0];

    always_comb
    begin
        st.nx = NX_ADV;
        if (phase_reg == PH_DRAIN)
        begin
            st.nx = NX_IDLE;
        end
        else if (load_reg == LD_LOW)
        begin
            st.nx = NX_FLUSH;
        end
        else if (load_reg == LD_HIGH)
        begin
            st.nx = NX_ADV;
        end
        else
        begin
            case (phase_reg)
                PH_LIT:  st.nx = NX_LIT;
                PH_MLO:  st.nx = NX_FLUSH;
                PH_MHI:  st.nx = (byte_reg[2:0] == 3'd0) ? NX_FLUSH : NX_COPY;
                PH_MCNT:
                begin
                    if (byte_reg == 8'd0)
                    begin
                        st.nx = NX_FLUSH;
                    end
                    else if (byte_reg == 8'd1)
                    begin
                        st.nx = NX_AFTER;
                    end
                    else
                    begin
                        st.nx = NX_COPY;
                    end
                end
                PH_INL:  st.nx = NX_COPY;
                default: st.nx = NX_ADV;
            endcase
        end
        st.put_full   = (pos_inc >= limit_reg);
        st.copy_bad   = ({2'b00, dist_reg} > pos_reg);
        st.lanes_full = (nlane_reg == 3'(OUT_LANES));
        st.cnt_last   = (cnt_reg == 9'd1);
        st.adv_more   = (load_reg == LD_NONE) && (phase_reg inside {[PH_FLAG1:PH_IB2]});
        st.flush_need = (nlane_reg != 3'd0) || (fin_stat != ST_DATA);
        st.out_free   = out_free;
    end

    always_comb
    begin
        limit_next  = cfg_write ? output_limit : limit_reg;
        pos_next    = pos_reg;
        desc_next   = desc_reg;
        left_next   = left_reg;
        phase_next  = phase_reg;
        load_next   = load_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        inl_next    = inl_reg;
        dist_next   = dist_reg;
        cnt_next    = cnt_reg;
        stat_next   = stat_reg;
        lanes_next  = lanes_reg;
        nlane_next  = nlane_reg;
        ovalid_next = ovalid_reg && out_stall;
        obytes_next = obytes_reg;
        ocount_next = ocount_reg;
        ostat_next  = ostat_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;
        put_en      = 1'b0;
        put_byte    = byte_reg;

        case (cmd)
            CMD_DECODE:
            begin
                if (phase_reg == PH_DRAIN)
                begin
                    if (eoi_reg)
                    begin
                        pos_next   = '0;
                        desc_next  = '0;
                        left_next  = '0;
                        phase_next = PH_FLAG1;
                        load_next  = LD_LOW;
                        plo_next   = '0;
                        phi_next   = '0;
                        inl_next   = '0;
                    end
                end
                else if (load_reg == LD_LOW)
                begin
                    plo_next  = byte_reg;
                    load_next = LD_HIGH;
                end
                else if (load_reg == LD_HIGH)
                begin
                    desc_next = {byte_reg, plo_reg};
                    left_next = 5'd16;
                    load_next = LD_NONE;
                end
                else
                begin
                    case (phase_reg)
                        PH_LIT:
                        begin
                            put_en = 1'b1;
                        end
                        PH_MLO:
                        begin
                            plo_next   = byte_reg;
                            phase_next = PH_MHI;
                        end
                        PH_MHI:
                        begin
                            phi_next = byte_reg;
                            if (byte_reg[2:0] == 3'd0)
                            begin
                                phase_next = PH_MCNT;
                            end
                            else
                            begin
                                dist_next = 14'h2000 - {1'b0, byte_reg[7:3], plo_reg};
                                cnt_next  = {6'd0, byte_reg[2:0]} + 9'd2;
                            end
                        end
                        PH_MCNT:
                        begin
                            if (byte_reg == 8'd0)
                            begin
                                stat_next = ST_FINISHED;
                            end
                            else
                            begin
                                dist_next = 14'h2000 - {1'b0, phi_reg[7:3], plo_reg};
                                cnt_next  = {1'b0, byte_reg} + 9'd1;
                            end
                        end
                        PH_INL:
                        begin
                            // distance 256 - b
                            dist_next = 14'h0100 - {6'd0, byte_reg};
                            cnt_next  = {7'd0, inl_reg} + 9'd2;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_CHECK:
            begin
                if ({2'b00, dist_reg} > pos_reg)
                begin
                    stat_next = ST_BAD_OFS;
                end
            end
            CMD_PUSH:
            begin
                ovalid_next = 1'b1;
                obytes_next = lanes_reg;
                ocount_next = nlane_reg;
                ostat_next  = ST_DATA;
                olen_next   = pos_reg;
                olast_next  = 1'b0;
                lanes_next  = '0;
                nlane_next  = '0;
            end
            CMD_WRITE:
            begin
                put_en   = 1'b1;
                put_byte = rd_data_reg;
                cnt_next = cnt_reg - 9'd1;
            end
            CMD_AFTER:
            begin
                phase_next = PH_FLAG1;
            end
            CMD_ADV:
            begin
                desc_next = desc_reg >> 1;
                left_next = left_reg - 5'd1;
                if (left_reg == 5'd1)
                begin
                    load_next = LD_LOW;
                end
                case (phase_reg)
                    PH_FLAG1: phase_next = bit0 ? PH_LIT : PH_FLAG2;
                    PH_FLAG2: phase_next = bit0 ? PH_MLO : PH_IB1;
                    PH_IB1:
                    begin
                        inl_next   = {bit0, 1'b0};
                        phase_next = PH_IB2;
                    end
                    default:
                    begin
                        inl_next   = {inl_reg[1], bit0};
                        phase_next = PH_INL;
                    end
                endcase
            end
            CMD_FLUSH:
            begin
                if (st.flush_need)
                begin
                    ovalid_next = 1'b1;
                    obytes_next = lanes_reg;
                    ocount_next = nlane_reg;
                    ostat_next  = fin_stat;
                    olen_next   = pos_reg;
                    olast_next  = 1'b1;
                end
                lanes_next = '0;
                nlane_next = '0;
                stat_next  = ST_DATA;
                if (fin_stat != ST_DATA)
                begin
                    if (eoi_reg)
                    begin
                        pos_next   = '0;
                        desc_next  = '0;
                        left_next  = '0;
                        phase_next = PH_FLAG1;
                        load_next  = LD_LOW;
                        plo_next   = '0;
                        phi_next   = '0;
                        inl_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_DRAIN;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // one byte into the window and the lane buffer
        if (put_en)
        begin
            pos_next = pos_inc;
            case (nlane_reg)
                3'd0:    lanes_next[7:0]   = put_byte;
                3'd1:    lanes_next[15:8]  = put_byte;
                3'd2:    lanes_next[23:16] = put_byte;
                default: lanes_next[31:24] = put_byte;
            endcase
            nlane_next = nlane_reg + 3'd1;
            if (pos_inc >= limit_reg)
            begin
                stat_next = ST_FULL;
            end
        end
    end

    assign we = put_en;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[pos_reg[WIN_AW-1:0]] <= put_byte;
        end
        if (cmd == CMD_READ)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            byte_reg <= in_byte;
            eoi_reg  <= end_of_input;
        end
        dist_reg   <= dist_next;
        cnt_reg    <= cnt_next;
        obytes_reg <= obytes_next;
        ocount_reg <= ocount_next;
        ostat_reg  <= ostat_next;
        olen_reg   <= olen_next;
        olast_reg  <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            pos_reg    <= '0;
            desc_reg   <= '0;
            left_reg   <= '0;
            phase_reg  <= PH_FLAG1;
            load_reg   <= LD_LOW;
            plo_reg    <= '0;
            phi_reg    <= '0;
            inl_reg    <= '0;
            stat_reg   <= ST_DATA;
            lanes_reg  <= '0;
            nlane_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            limit_reg  <= limit_next;
            pos_reg    <= pos_next;
            desc_reg   <= desc_next;
            left_reg   <= left_next;
            phase_reg  <= phase_next;
            load_reg   <= load_next;
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            inl_reg    <= inl_next;
            stat_reg   <= stat_next;
            lanes_reg  <= lanes_next;
            nlane_reg  <= nlane_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_bytes    = obytes_reg;
    assign byte_count   = ocount_reg;
    assign status       = ostat_reg;
    assign total_length = olen_reg;
    assign last         = olast_reg;

endmodule

// ----- rtl/core/kosinski_lz_decompressor.sv -----
// top level of the kosinski decompressor: controller plus datapath
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         in_valid / in_stall  in_byte, end_of_input
// output    out        out_valid/out_stall  out_bytes, byte_count, status,
//                                           total_length, last
// config    in         cfg_valid/cfg_ready  output_limit
//
// an item passes through accept, decode and flush; a finished command adds a phase
// reset, a step per flag bit (at most 4) and a loop exit; a match adds a check,
// a read plus a write per byte and a push per mid-copy item
// reset clears parse state, limit 65535; history reads never reach unwritten entries
// an output stall holds the block only when a full four-byte item or the final
// item of a step must leave while the output register is occupied

module kosinski_lz_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] output_limit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_bytes,
    output logic [2:0]  byte_count,
    output logic [2:0]  status,
    output logic [15:0] total_length,
    output logic        last
);
    import kld_pkg::*;

    dp_status_t st;
    cmd_t       cmd;

    // the user writes the limit only while idle (not enforced here), so always ready
    assign cfg_ready = 1'b1;

    kld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    kld_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .cfg_write    (cfg_valid && cfg_ready),
        .output_limit (output_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_bytes    (out_bytes),
        .byte_count   (byte_count),
        .status       (status),
        .total_length (total_length),
        .last         (last)
    );

`ifndef SYNTHESIS
    // items before the final one of a step are always full
    a_full_chunks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> byte_count == 3'd4)
        else $error("non-final item not full");

    // a terminal status rides only on the final item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DATA |-> last)
        else $error("status on non-final item");

    // an item with no bytes must carry a status
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == 3'd0 |-> status != ST_DATA)
        else $error("empty item without status");
`endif

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the kosinski decompressor
`timescale 1ns / 1ps

module tb_top;
    import kld_pkg::*;

    // the scoreboard mirrors the decoder: descriptor bits, parse phase, history window
    // and output position, and packs the bytes each input item yields into
    // four-lane result items that wait in a queue for the output monitor
    class kld_scoreboard;

        typedef struct {
            logic [31:0] data;
            logic [2:0]  cnt;
            logic [2:0]  st;
            logic [15:0] tot;
            logic        lst;
        } result_t;

        logic [7:0]  window [WINDOW_DEPTH];
        logic [15:0] out_pos;
        logic [15:0] limit;
        logic [15:0] desc;
        int          desc_left;
        phase_t      ph;
        load_t       ld;
        logic [7:0]  lo_byte;
        logic [7:0]  hi_byte;
        logic [1:0]  inl_cnt;
        logic [7:0]  emitted[$];
        logic [2:0]  st_now;
        result_t     waiting[$];
        int          errors;

        function new();
            limit  = LIMIT_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            out_pos   = '0;
            desc      = '0;
            desc_left = 0;
            ph        = PH_FLAG1;
            ld        = LD_LOW;
            lo_byte   = '0;
            hi_byte   = '0;
            inl_cnt   = '0;
        endfunction

        function void set_limit(logic [15:0] v);
            limit = v;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        // consume flag bits until a byte is needed or a descriptor reload is due
        function void advance();
            logic b;
            while (ld == LD_NONE && ph <= PH_IB2) begin
                b         = desc[0];
                desc      = desc >> 1;
                desc_left = desc_left - 1;
                if (desc_left == 0)
                    ld = LD_LOW;
                case (ph)
                    PH_FLAG1: ph = b ? PH_LIT : PH_FLAG2;
                    PH_FLAG2: ph = b ? PH_MLO : PH_IB1;
                    PH_IB1:
                    begin
                        inl_cnt = {b, 1'b0};
                        ph      = PH_IB2;
                    end
                    default:
                    begin
                        inl_cnt[0] = b;
                        ph         = PH_INL;
                    end
                endcase
            end
        endfunction

        // returns 1 once the output limit is hit
        function bit put(logic [7:0] b);
            window[out_pos[WIN_AW-1:0]] = b;
            emitted.push_back(b);
            out_pos = out_pos + 16'd1;
            if (out_pos >= limit) begin
                st_now = ST_FULL;
                return 1;
            end
            return 0;
        endfunction

        function void copy(int span, int count);
            logic [15:0] src;
            if (span > out_pos) begin
                st_now = ST_BAD_OFS;
                return;
            end
            for (int i = 0; i < count; i++) begin
                src = out_pos - 16'(span);
                if (put(window[src[WIN_AW-1:0]]))
                    return;
            end
        endfunction

        function void after_cmd();
            if (st_now == ST_DATA) begin
                ph = PH_FLAG1;
                advance();
            end
        endfunction

        function int far_dist(logic [7:0] hi, logic [7:0] lo);
            return 32'h2000 - ((int'(hi >> 3) << 8) | int'(lo));
        endfunction

        function void note_input(logic [7:0] b, logic eoi);
            logic [15:0] start;
            result_t     r;
            int          done;
            int          k;
            int          m;
            start = out_pos;
            emitted.delete();
            st_now = ST_DATA;
            if (ph == PH_DRAIN) begin
                if (eoi)
                    restart();
                return;
            end
            if (ld == LD_LOW) begin
                lo_byte = b;
                ld      = LD_HIGH;
            end else if (ld == LD_HIGH) begin
                desc      = {b, lo_byte};
                desc_left = 16;
                ld        = LD_NONE;
                advance();
            end else begin
                case (ph)
                    PH_LIT:
                    begin
                        void'(put(b));
                        after_cmd();
                    end
                    PH_MLO:
                    begin
                        lo_byte = b;
                        ph      = PH_MHI;
                    end
                    PH_MHI:
                    begin
                        hi_byte = b;
                        if (b[2:0] == 3'd0)
                            ph = PH_MCNT;
                        else begin
                            copy(far_dist(b, lo_byte), int'(b[2:0]) + 2);
                            after_cmd();
                        end
                    end
                    PH_MCNT:
                    begin
                        if (b == 8'd0)
                            st_now = ST_FINISHED;
                        else begin
                            if (b > 8'd1)
                                copy(far_dist(hi_byte, lo_byte), int'(b) + 1);
                            after_cmd();
                        end
                    end
                    PH_INL:
                    begin
                        copy(256 - int'(b), int'(inl_cnt) + 2);
                        after_cmd();
                    end
                    default: advance();
                endcase
            end
            if (st_now == ST_DATA && eoi)
                st_now = ST_TRUNC;
            done = 0;
            k    = 0;
            while (done < emitted.size() || (k == 0 && st_now != ST_DATA)) begin
                m = emitted.size() - done;
                if (m > OUT_LANES)
                    m = OUT_LANES;
                r.data = '0;
                for (int j = 0; j < m; j++)
                    r.data[8*j +: 8] = emitted[done + j];
                done  = done + m;
                r.cnt = 3'(m);
                r.lst = (done >= emitted.size());
                r.st  = r.lst ? st_now : ST_DATA;
                r.tot = start + 16'(done);
                waiting.push_back(r);
                k++;
            end
            if (st_now != ST_DATA) begin
                if (eoi)
                    restart();
                else
                    ph = PH_DRAIN;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("result error: %s got %h expected %h", what, got, want);
            errors++;
        endtask

        task check(logic [31:0] data, logic [2:0] cnt, logic [2:0] st, logic [15:0] tot,
                   logic lst);
            result_t e;
            if (waiting.size() == 0) begin
                report("unexpected item", data, 0);
                return;
            end
            e = waiting.pop_front();
            if (data !== e.data) report("out_bytes", data, e.data);
            if (cnt !== e.cnt)   report("byte_count", cnt, e.cnt);
            if (st !== e.st)     report("status", st, e.st);
            if (tot !== e.tot)   report("total_length", tot, e.tot);
            if (lst !== e.lst)   report("last", lst, e.lst);
        endtask
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    // let a 256-byte copy drain before config writes
    localparam int SETTLE_CYCLES  = 800;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        end_of_input;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] output_limit;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_bytes;
    logic [2:0]  byte_count;
    logic [2:0]  status;
    logic [15:0] total_length;
    logic        last;

    kld_scoreboard sb;

    // stream builder state
    logic [7:0]  stream[$];
    int          desc_at;
    int          desc_bits;
    logic [15:0] desc_word;
    int          gen_pos;

    // sender burst state
    int          burst_left;
    int          sent_items;
    int          idle_count;

    kosinski_lz_decompressor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .output_limit (output_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_bytes    (out_bytes),
        .byte_count   (byte_count),
        .status       (status),
        .total_length (total_length),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // stream builder: descriptor slots are reserved in the byte stream
    // and filled once their sixteen flag bits are known; a new slot is
    // reserved right after the sixteenth bit, ahead of any data byte
    // ---------------------------------------------------------------
    task reserve_desc();
        desc_at   = stream.size();
        desc_bits = 0;
        desc_word = '0;
        stream.push_back(8'h00);
        stream.push_back(8'h00);
    endtask

    task close_desc();
        stream[desc_at]     = desc_word[7:0];
        stream[desc_at + 1] = desc_word[15:8];
    endtask

    task gen_open();
        stream.delete();
        gen_pos = 0;
        reserve_desc();
    endtask

    task gen_bit(logic b);
        desc_word[desc_bits] = b;
        desc_bits++;
        if (desc_bits == 16) begin
            close_desc();
            reserve_desc();
        end
    endtask

    task g_lit(logic [7:0] b);
        gen_bit(1'b1);
        stream.push_back(b);
        gen_pos++;
    endtask

    // inline match: two count bits high first, then 256 - distance
    task g_inline(int n, int span);
        gen_bit(1'b0);
        gen_bit(1'b0);
        gen_bit(n[1]);
        gen_bit(n[0]);
        stream.push_back(8'(256 - span));
        gen_pos += n + 2;
    endtask

    // far match; cnt3 of zero means an extended count byte follows
    task g_far(int span, logic [2:0] cnt3, logic [7:0] ext);
        logic [12:0] ofs;
        ofs = 13'(32'h2000 - span);
        gen_bit(1'b0);
        gen_bit(1'b1);
        stream.push_back(ofs[7:0]);
        stream.push_back({ofs[12:8], cnt3});
        if (cnt3 != 3'd0) begin
            gen_pos += int'(cnt3) + 2;
        end else begin
            stream.push_back(ext);
            if (ext > 8'd1)
                gen_pos += int'(ext) + 1;
        end
    endtask

    task g_end();
        logic [7:0] hi;
        hi = 8'($urandom) & 8'hF8;
        gen_bit(1'b0);
        gen_bit(1'b1);
        stream.push_back(8'($urandom));
        stream.push_back(hi);
        stream.push_back(8'h00);
        close_desc();
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------
    task send_byte(logic [7:0] b, logic eoi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note_input(b, eoi);
        sent_items++;
    endtask

    // send the first n bytes of the built stream, eoi on the last if asked
    task send_stream(int n, logic eoi_last);
        for (int i = 0; i < n; i++)
            send_byte(stream[i], eoi_last && (i == n - 1));
    endtask

    task send_noise(int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 5) == 0));
    endtask

    task drain_and_settle();
        @(posedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_limit(logic [15:0] v);
        cfg_valid    <= 1'b1;
        output_limit <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sb.set_limit(v);
        cfg_valid <= 1'b0;
    endtask

    // one random command with mostly valid distances, sometimes a bad one
    task g_random_cmd();
        int r;
        int far;
        int span;
        r = $urandom_range(0, 9);
        if (gen_pos == 0 || r < 4) begin
            g_lit(8'($urandom));
        end else if (r < 6) begin
            far = (gen_pos < 256) ? gen_pos : 256;
            if ($urandom_range(0, 19) == 0 && gen_pos < 256)
                span = $urandom_range(gen_pos + 1, 256);
            else
                span = $urandom_range(1, far);
            g_inline($urandom_range(0, 3), span);
        end else begin
            far = (gen_pos < 8192) ? gen_pos : 8192;
            if ($urandom_range(0, 19) == 0)
                span = $urandom_range(gen_pos + 1, 8192);
            else
                span = $urandom_range(1, far);
            if (r < 9)
                g_far(span, 3'($urandom_range(1, 7)), 8'h00);
            else if ($urandom_range(0, 7) == 0)
                g_far(span, 3'd0, ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd255);
            else
                g_far(span, 3'd0, 8'($urandom_range(2, 24)));
        end
    endtask

    task random_phase(int items);
        int stop_at;
        int kind;
        int ncmd;
        stop_at = sent_items + items;
        while (sent_items < stop_at) begin
            kind = $urandom_range(0, 9);
            ncmd = $urandom_range(1, 10);
            gen_open();
            for (int i = 0; i < ncmd; i++)
                g_random_cmd();
            g_end();
            if (kind < 7) begin
                // well-formed stream
                send_stream(stream.size(), 1'b1);
            end else if (kind == 7) begin
                // cut short: truncation
                send_stream($urandom_range(1, stream.size() - 1), 1'b1);
            end else if (kind == 8) begin
                // terminator without eoi, then bytes that get dropped
                send_stream(stream.size(), 1'b0);
                send_noise($urandom_range(1, 6));
            end else begin
                send_noise($urandom_range(1, 8));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // receiver stall pattern, redrawn at random from four modes by a tick counter
    // ---------------------------------------------------------------
    int stall_mode;
    int stall_tick;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_tick <= 0;
        end else begin
            stall_tick <= stall_tick + 1;
            if (stall_tick % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= (stall_tick % 5 < 2);
            endcase
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out_bytes, byte_count, status, total_length, last);
    end

    // watchdog: cycles with nothing accepted on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("kosinski_lz_decompressor: mismatch");
            $finish;
        end
    end

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = '0;
        end_of_input = 1'b0;
        cfg_valid    = 1'b0;
        output_limit = '0;
        idle_count   = 0;
        burst_left   = 0;
        sent_items   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_limit(16'hFFFF);

        // directed: literal extremes, inline and far matches, no-op count,
        // longest extended count, distance 256, then an offset before start
        gen_open();
        g_lit(8'hFF);
        g_lit(8'h00);
        g_inline(3, 1);
        g_far(2, 3'd7, 8'h00);
        g_far(1, 3'd0, 8'd1);
        g_far(1, 3'd0, 8'd255);
        g_inline(0, 256);
        g_far(8192, 3'd1, 8'h00);
        g_end();
        send_stream(stream.size(), 1'b1);

        // truncated stream, then a clean finish with a dropped tail
        gen_open();
        g_lit(8'h5A);
        g_inline(1, 1);
        g_end();
        send_stream(3, 1'b1);
        send_stream(stream.size(), 1'b0);
        send_noise(2);

        random_phase(50);
        drain_and_settle();

        // smallest limit: the first byte fills the output
        write_limit(16'd1);
        random_phase(20);
        drain_and_settle();

        write_limit(16'd20);
        random_phase(30);
        drain_and_settle();

        write_limit(16'hAAAA);
        random_phase(30);

        drain_and_settle();
        if (sb.errors == 0)
            $display("kosinski_lz_decompressor: match");
        else
            $display("kosinski_lz_decompressor: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/kld_pkg.sv
rtl/core/kld_ctrl.sv
rtl/core/kld_datapath.sv
rtl/core/kosinski_lz_decompressor.sv
test/tb_top.sv
